@@ hdl/srp_pkg.sv @@
// ----------------------------------------------------------------------------
// srp_pkg
// Shared types, operation codes, register indexes and arithmetic helpers for
// the stereo ring player.
// ----------------------------------------------------------------------------
package srp_pkg;

  localparam logic [2:0] OP_PUSH  = 3'd0;
  localparam logic [2:0] OP_TICK  = 3'd1;
  localparam logic [2:0] OP_CTRL  = 3'd2;
  localparam logic [2:0] OP_FLUSH = 3'd3;
  localparam logic [2:0] OP_PLAY  = 3'd4;

  localparam logic [1:0] REG_DEADBAND = 2'd0;
  localparam logic [1:0] REG_RISE     = 2'd1;
  localparam logic [1:0] REG_FALL     = 2'd2;
  localparam logic [1:0] REG_SHIFT    = 2'd3;

  localparam logic [11:0] DEADBAND_RST = 12'd60;
  localparam logic [11:0] RISE_RST     = 12'd900;
  localparam logic [11:0] FALL_RST     = 12'd350;
  localparam logic [3:0]  SHIFT_RST    = 4'd9;
  localparam logic [11:0] FLOOR_RST    = 12'd4095;
  localparam logic [1:0]  TRIG_RST     = 2'b11;

  localparam logic [15:0] GAIN_ONE  = 16'h8000;
  localparam logic [24:0] GAIN_SLEW = 25'd492;
  localparam logic [24:0] SLEW_RND  = 25'd32767;
  localparam logic [15:0] DECAY_MUL = 16'd30802;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [15:0] push_left;
    logic signed [15:0] push_right;
    logic [1:0]         trigger_levels;
    logic [11:0]        cv_length;
    logic [11:0]        cv_position;
    logic [11:0]        cv_clock;
    logic               hold;
    logic               seek;
    logic               play_value;
  } item_t;

  typedef struct packed {
    logic accept;
    logic commit;
  } seq_t;

  typedef struct packed {
    logic [11:0] deadband;
    logic [11:0] rise;
    logic [11:0] fall;
    logic [3:0]  shift;
  } cfg_t;

  typedef struct packed {
    logic        playing;
    logic        loop_toggle;
    logic [5:0]  loop_length;
    logic [11:0] loop_position;
    logic        clock_level;
  } cv_stat_t;

  function automatic logic [5:0] len_step(input logic [2:0] idx);
    logic [5:0] r;
    case (idx)
      3'd0:    r = 6'd1;
      3'd1:    r = 6'd2;
      3'd2:    r = 6'd4;
      3'd3:    r = 6'd8;
      3'd4:    r = 6'd16;
      default: r = 6'd32;
    endcase
    return r;
  endfunction

  // Signed sample times an unsigned Q1.15 factor, truncated toward zero.
  function automatic logic signed [15:0] scale_q15(input logic signed [15:0] x,
                                                   input logic [15:0] mul);
    logic [16:0] mag;
    logic [32:0] prod;
    logic [16:0] r;
    logic [16:0] neg;
    mag  = x[15] ? (17'd0 - {x[15], x}) : {1'b0, x};
    prod = {16'd0, mag} * {17'd0, mul};
    r    = prod[31:15];
    neg  = 17'd0 - r;
    return x[15] ? neg[15:0] : r[15:0];
  endfunction

endpackage

@@ hdl/srp_ring.sv @@
// ----------------------------------------------------------------------------
// srp_ring
// Sample ring storage: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module srp_ring #(
  parameter int unsigned RING_FRAMES = 32768,
  localparam int unsigned PtrW = $clog2(RING_FRAMES)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [PtrW-1:0] waddr_i,
  input  logic [31:0]     wdata_i,
  input  logic            re_i,
  input  logic [PtrW-1:0] raddr_i,
  output logic [31:0]     rdata_o
);

  logic [31:0] mem [RING_FRAMES];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/srp_play.sv @@
// ----------------------------------------------------------------------------
// srp_play
// Playback path: ring pointers and counters, gain slew, sample scaling and
// idle decay.
// ----------------------------------------------------------------------------
module srp_play #(
  parameter int unsigned RING_FRAMES = 32768,
  localparam int unsigned PtrW = $clog2(RING_FRAMES)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  srp_pkg::seq_t      seq_i,
  input  srp_pkg::item_t     item_in_i,
  input  srp_pkg::item_t     item_i,
  input  logic               playing_i,
  output logic signed [15:0] left_o,
  output logic signed [15:0] right_o,
  output logic               starved_o
);
  import srp_pkg::*;

  localparam logic [PtrW-1:0] PtrLast = PtrW'(RING_FRAMES - 1);

  logic [31:0]        wr_cnt_q, rd_cnt_q, rd_next;
  logic [PtrW-1:0]    wr_ptr_q, rd_ptr_q, wr_ptr_inc, rd_ptr_inc;
  logic [15:0]        gain_q, gain_d, tgt, diff;
  logic [24:0]        slew_sum;
  logic [9:0]         step;
  logic               up;
  logic signed [15:0] last_l_q, last_r_q, last_l_d, last_r_d;
  logic signed [15:0] src_l, src_r;
  logic [15:0]        mul;
  logic               play_ok_in, starved_in, play_ok_q, starved_q;
  logic [31:0]        rdata;
  logic               is_tick;

  srp_ring #(.RING_FRAMES(RING_FRAMES)) u_ring (
    .clk_i   (clk_i),
    .we_i    (seq_i.commit && (item_i.op == OP_PUSH)),
    .waddr_i (wr_ptr_q),
    .wdata_i ({item_i.push_right, item_i.push_left}),
    .re_i    (seq_i.accept),
    .raddr_i (rd_ptr_q),
    .rdata_o (rdata)
  );

  always_comb begin
    rd_next     = rd_cnt_q + 32'd1;
    play_ok_in  = playing_i && !item_in_i.hold && (rd_next < wr_cnt_q);
    starved_in  = !play_ok_in && playing_i && !item_in_i.hold && !item_in_i.seek &&
                  (wr_cnt_q != 32'd0);
    tgt         = play_ok_in ? GAIN_ONE : 16'd0;
    up          = tgt > gain_q;
    diff        = up ? (tgt - gain_q) : (gain_q - tgt);
    slew_sum    = ({9'd0, diff} * GAIN_SLEW) + SLEW_RND;
    step        = slew_sum[24:15];
    gain_d      = up ? (gain_q + {6'd0, step}) : (gain_q - {6'd0, step});
  end

  always_comb begin
    src_l      = play_ok_q ? $signed(rdata[15:0])  : last_l_q;
    src_r      = play_ok_q ? $signed(rdata[31:16]) : last_r_q;
    mul        = play_ok_q ? gain_q : DECAY_MUL;
    last_l_d   = scale_q15(src_l, mul);
    last_r_d   = scale_q15(src_r, mul);
    wr_ptr_inc = ((wr_ptr_q == PtrLast) || (wr_cnt_q == '1)) ? '0 : wr_ptr_q + PtrW'(1);
    rd_ptr_inc = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (seq_i.accept && (item_in_i.op == OP_TICK)) begin
      play_ok_q <= play_ok_in;
      starved_q <= starved_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_cnt_q <= '0;
      rd_cnt_q <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      gain_q   <= '0;
      last_l_q <= '0;
      last_r_q <= '0;
    end else begin
      if (seq_i.accept && (item_in_i.op == OP_TICK)) begin
        gain_q <= gain_d;
      end
      if (seq_i.commit) begin
        case (item_i.op)
          OP_PUSH: begin
            wr_cnt_q <= wr_cnt_q + 32'd1;
            wr_ptr_q <= wr_ptr_inc;
          end
          OP_TICK: begin
            last_l_q <= last_l_d;
            last_r_q <= last_r_d;
            if (play_ok_q) begin
              rd_cnt_q <= rd_cnt_q + 32'd1;
              rd_ptr_q <= rd_ptr_inc;
            end
          end
          OP_FLUSH: begin
            wr_cnt_q <= '0;
            rd_cnt_q <= '0;
            wr_ptr_q <= '0;
            rd_ptr_q <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign is_tick   = item_i.op == OP_TICK;
  assign left_o    = is_tick ? last_l_d : '0;
  assign right_o   = is_tick ? last_r_d : '0;
  assign starved_o = is_tick && starved_q;

endmodule

@@ hdl/srp_cv.sv @@
// ----------------------------------------------------------------------------
// srp_cv
// Control conditioning: gate edge detection, play state, CV deadbands, length
// mapping and the floor-tracking Schmitt clock.
// ----------------------------------------------------------------------------
module srp_cv (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  srp_pkg::seq_t     seq_i,
  input  srp_pkg::item_t    item_i,
  input  srp_pkg::cfg_t     cfg_i,
  output logic              playing_o,
  output srp_pkg::cv_stat_t stat_o
);
  import srp_pkg::*;

  logic [1:0]  prev_q, prev_d, fell;
  logic        playing_q, playing_d;
  logic [11:0] held_len_q, held_len_d, held_pos_q, held_pos_d;
  logic [11:0] dl, dp, cl, cp, cc;
  logic        valid_q, valid_d;
  logic [11:0] floor_q, floor_d, rise_amt;
  logic [12:0] rise_lim, fall_lim;
  logic        clk_q, clk_d;
  logic        is_ctrl, is_play;
  logic [14:0] len_prod;

  always_comb begin
    is_ctrl  = item_i.op == OP_CTRL;
    is_play  = item_i.op == OP_PLAY;
    cl       = item_i.cv_length;
    cp       = item_i.cv_position;
    cc       = item_i.cv_clock;
    fell     = prev_q & ~item_i.trigger_levels;
    prev_d   = is_ctrl ? item_i.trigger_levels : prev_q;

    if (is_ctrl && fell[0]) begin
      playing_d = !playing_q;
    end else if (is_play) begin
      playing_d = item_i.play_value;
    end else begin
      playing_d = playing_q;
    end

    dl         = (cl > held_len_q) ? (cl - held_len_q) : (held_len_q - cl);
    dp         = (cp > held_pos_q) ? (cp - held_pos_q) : (held_pos_q - cp);
    held_len_d = (is_ctrl && (!valid_q || (dl > cfg_i.deadband))) ? cl : held_len_q;
    held_pos_d = (is_ctrl && (!valid_q || (dp > cfg_i.deadband))) ? cp : held_pos_q;
    valid_d    = valid_q || is_ctrl;

    rise_amt = (cc - floor_q) >> cfg_i.shift;
    if (!is_ctrl) begin
      floor_d = floor_q;
    end else if (cc < floor_q) begin
      floor_d = cc;
    end else begin
      floor_d = floor_q + rise_amt;
    end
    rise_lim = {1'b0, floor_d} + {1'b0, cfg_i.rise};
    fall_lim = {1'b0, floor_d} + {1'b0, cfg_i.fall};
    if (is_ctrl && !clk_q && ({1'b0, cc} > rise_lim)) begin
      clk_d = 1'b1;
    end else if (is_ctrl && clk_q && ({1'b0, cc} < fall_lim)) begin
      clk_d = 1'b0;
    end else begin
      clk_d = clk_q;
    end

    len_prod = {1'b0, held_len_d, 2'b00} + {2'b00, held_len_d, 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= TRIG_RST;
      playing_q  <= 1'b0;
      held_len_q <= '0;
      held_pos_q <= '0;
      valid_q    <= 1'b0;
      floor_q    <= FLOOR_RST;
      clk_q      <= 1'b0;
    end else if (seq_i.commit) begin
      prev_q     <= prev_d;
      playing_q  <= playing_d;
      held_len_q <= held_len_d;
      held_pos_q <= held_pos_d;
      valid_q    <= valid_d;
      floor_q    <= floor_d;
      clk_q      <= clk_d;
    end
  end

  assign playing_o            = playing_q;
  assign stat_o.playing       = playing_d;
  assign stat_o.loop_toggle   = is_ctrl && fell[1];
  assign stat_o.loop_length   = len_step(len_prod[14:12]);
  assign stat_o.loop_position = held_pos_d;
  assign stat_o.clock_level   = clk_d;

endmodule

@@ hdl/stereo_ring_player_with_cv_conditioning.sv @@
// ----------------------------------------------------------------------------
// stereo_ring_player_with_cv_conditioning
// Stereo sample ring with gain-slewed playback and control-voltage
// conditioning, behind valid/stall channels and an APB register port.
// ----------------------------------------------------------------------------
// The ring memory is read at the transfer and its data is registered; the
// item is finished from the EXEC state, once the output register can take its
// result. One item is in work at a time; a new item is taken while the
// previous result still waits in the output register, and finishing stalls
// only while that register is full and the output is stalled.
// The ring is not cleared after reset, so the block is ready at once.
module stereo_ring_player_with_cv_conditioning #(
  parameter int unsigned RING_FRAMES = 32768
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         op_i,
  input  logic signed [15:0] push_left_i,
  input  logic signed [15:0] push_right_i,
  input  logic [1:0]         trigger_levels_i,
  input  logic [11:0]        cv_length_i,
  input  logic [11:0]        cv_position_i,
  input  logic [11:0]        cv_clock_i,
  input  logic               producer_hold_i,
  input  logic               seek_pending_i,
  input  logic               play_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] left_out_o,
  output logic signed [15:0] right_out_o,
  output logic               starved_o,
  output logic               is_playing_o,
  output logic               loop_toggle_o,
  output logic [5:0]         loop_length_o,
  output logic [11:0]        loop_position_o,
  output logic               clock_level_o
);
  import srp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e             state_q, state_d;
  cfg_t               cfg_q;
  item_t              item_in, item_q;
  seq_t               seq;
  logic               cfg_we;
  logic               out_valid_q;
  logic signed [15:0] left_q, right_q, left_d, right_d;
  logic               starved_q, starved_d;
  cv_stat_t           stat_q, stat_d;
  logic               playing;

  assign item_in.op             = op_i;
  assign item_in.push_left      = push_left_i;
  assign item_in.push_right     = push_right_i;
  assign item_in.trigger_levels = trigger_levels_i;
  assign item_in.cv_length      = cv_length_i;
  assign item_in.cv_position    = cv_position_i;
  assign item_in.cv_clock       = cv_clock_i;
  assign item_in.hold           = producer_hold_i;
  assign item_in.seek           = seek_pending_i;
  assign item_in.play_value     = play_value_i;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deadband <= DEADBAND_RST;
      cfg_q.rise     <= RISE_RST;
      cfg_q.fall     <= FALL_RST;
      cfg_q.shift    <= SHIFT_RST;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_DEADBAND: cfg_q.deadband <= pwdata[11:0];
        REG_RISE:     cfg_q.rise     <= pwdata[11:0];
        REG_FALL:     cfg_q.fall     <= pwdata[11:0];
        REG_SHIFT:    cfg_q.shift    <= pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DEADBAND: prdata = {20'd0, cfg_q.deadband};
      REG_RISE:     prdata = {20'd0, cfg_q.rise};
      REG_FALL:     prdata = {20'd0, cfg_q.fall};
      REG_SHIFT:    prdata = {28'd0, cfg_q.shift};
      default:      prdata = '0;
    endcase
  end

  assign in_stall_o = state_q != ST_IDLE;
  assign seq.accept = in_valid_i && !in_stall_o;
  assign seq.commit = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (seq.accept) state_d = ST_EXEC;
      ST_EXEC: if (seq.commit) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (seq.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq.accept) begin
      item_q <= item_in;
    end
    if (seq.commit) begin
      left_q    <= left_d;
      right_q   <= right_d;
      starved_q <= starved_d;
      stat_q    <= stat_d;
    end
  end

  srp_play #(.RING_FRAMES(RING_FRAMES)) u_play (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .seq_i     (seq),
    .item_in_i (item_in),
    .item_i    (item_q),
    .playing_i (playing),
    .left_o    (left_d),
    .right_o   (right_d),
    .starved_o (starved_d)
  );

  srp_cv u_cv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .seq_i     (seq),
    .item_i    (item_q),
    .cfg_i     (cfg_q),
    .playing_o (playing),
    .stat_o    (stat_d)
  );

  assign out_valid_o     = out_valid_q;
  assign left_out_o      = left_q;
  assign right_out_o     = right_q;
  assign starved_o       = starved_q;
  assign is_playing_o    = stat_q.playing;
  assign loop_toggle_o   = stat_q.loop_toggle;
  assign loop_length_o   = stat_q.loop_length;
  assign loop_position_o = stat_q.loop_position;
  assign clock_level_o   = stat_q.clock_level;

endmodule

@@ hdl/srp_checker.sv @@
// ----------------------------------------------------------------------------
// srp_checker
// Port-level checks for the stereo ring player, bound to the top level.
// ----------------------------------------------------------------------------
module srp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] left_out_o,
  input logic        starved_o,
  input logic        is_playing_o,
  input logic [5:0]  loop_length_o
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(left_out_o)))
    else $error("stalled result changed");

  // One item in work at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second transfer taken while an item is in work");

  // Starvation is only reported while playing.
  a_starved_playing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && starved_o) |-> is_playing_o)
    else $error("starvation reported while not playing");

  // The loop length is always one of the power-of-two steps.
  a_len_pow2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot(loop_length_o))
    else $error("loop length is not a power of two");

endmodule

bind stereo_ring_player_with_cv_conditioning srp_checker u_srp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .left_out_o    (left_out_o),
  .starved_o     (starved_o),
  .is_playing_o  (is_playing_o),
  .loop_length_o (loop_length_o)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the stereo ring player. A scoreboard class
// predicts the result of every accepted transfer and compares it field by
// field with what the block returns. Stimulus runs a directed part, a push
// burst that is played out until the ring runs dry, and random phases under
// several register settings and handshake idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import srp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int          UNITY_GAIN  = 32768;
  localparam int          SLEW_NUM    = 492;
  localparam int          DECAY_NUM   = 30802;

  typedef struct packed {
    logic signed [15:0] left_smp;
    logic signed [15:0] right_smp;
    logic               starved;
    logic               playing;
    logic               loop_toggle;
    logic [5:0]         len_steps;
    logic [11:0]        loop_pos;
    logic               clk_level;
  } frame_result_t;

  class player_checker;
    logic [31:0]   ring_mem [0:32767];
    logic [31:0]   wr_count;
    logic [31:0]   rd_count;
    int            gain;
    int            last_l;
    int            last_r;
    logic [1:0]    trig_hist;
    int            held_len;
    int            held_pos;
    bit            holds_loaded;
    int            clk_floor;
    bit            clock_hi;
    bit            playing;
    int            deadband;
    int            rise_ofs;
    int            fall_ofs;
    int            floor_shift;
    frame_result_t expected_outputs [$];
    int            errors;

    function new();
      wr_count     = '0;
      rd_count     = '0;
      gain         = 0;
      last_l       = 0;
      last_r       = 0;
      trig_hist    = 2'b11;
      held_len     = 0;
      held_pos     = 0;
      holds_loaded = 1'b0;
      clk_floor    = 4095;
      clock_hi     = 1'b0;
      playing      = 1'b0;
      deadband     = 60;
      rise_ofs     = 900;
      fall_ofs     = 350;
      floor_shift  = 9;
      errors       = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [11:0] value);
      case (idx)
        REG_DEADBAND: deadband    = value;
        REG_RISE:     rise_ofs    = value;
        REG_FALL:     fall_ofs    = value;
        REG_SHIFT:    floor_shift = value[3:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_outputs.size();
    endfunction

    function int scaled(int x, int mul);
      longint mag;
      longint r;
      mag = (x < 0) ? -x : x;
      r   = (mag * mul) >>> 15;
      return (x < 0) ? -int'(r) : int'(r);
    endfunction

    function void slew_toward(int target);
      int diff;
      int step;
      diff = (target > gain) ? target - gain : gain - target;
      step = (diff * SLEW_NUM + 32767) >>> 15;
      gain = (target > gain) ? gain + step : gain - step;
    endfunction

    function int deadbanded(int held, int cv);
      int d;
      d = (cv > held) ? cv - held : held - cv;
      return (d > deadband) ? cv : held;
    endfunction

    function void note_item(item_t it);
      frame_result_t      res;
      bit                 play_ok;
      logic [1:0]         fell;
      logic [31:0]        word;
      logic signed [15:0] smp_l;
      logic signed [15:0] smp_r;
      int                 cc;
      int                 idx;
      res = '0;
      case (it.op)
        OP_PUSH: begin
          ring_mem[wr_count[14:0]] = {it.push_right, it.push_left};
          wr_count = wr_count + 32'd1;
        end
        OP_TICK: begin
          play_ok = playing && !it.hold && ((rd_count + 32'd1) < wr_count);
          res.starved = !play_ok && playing && !it.hold && !it.seek && (wr_count != 0);
          slew_toward(play_ok ? UNITY_GAIN : 0);
          if (play_ok) begin
            word   = ring_mem[rd_count[14:0]];
            smp_l  = word[15:0];
            smp_r  = word[31:16];
            last_l = scaled(smp_l, gain);
            last_r = scaled(smp_r, gain);
            rd_count = rd_count + 32'd1;
          end else begin
            last_l = scaled(last_l, DECAY_NUM);
            last_r = scaled(last_r, DECAY_NUM);
          end
          res.left_smp  = 16'(last_l);
          res.right_smp = 16'(last_r);
        end
        OP_CTRL: begin
          fell      = trig_hist & ~it.trigger_levels;
          trig_hist = it.trigger_levels;
          if (fell[0]) playing = !playing;
          res.loop_toggle = fell[1];
          if (!holds_loaded) begin
            held_len     = it.cv_length;
            held_pos     = it.cv_position;
            holds_loaded = 1'b1;
          end
          held_len = deadbanded(held_len, it.cv_length);
          held_pos = deadbanded(held_pos, it.cv_position);
          cc = it.cv_clock;
          if (cc < clk_floor) clk_floor = cc;
          else clk_floor = clk_floor + ((cc - clk_floor) >> floor_shift);
          if (!clock_hi && cc > clk_floor + rise_ofs) clock_hi = 1'b1;
          else if (clock_hi && cc < clk_floor + fall_ofs) clock_hi = 1'b0;
        end
        OP_FLUSH: begin
          wr_count = '0;
          rd_count = '0;
        end
        OP_PLAY: playing = it.play_value;
        default: ;
      endcase
      idx = (held_len * 6) / 4096;
      if (idx > 5) idx = 5;
      res.playing   = playing;
      res.len_steps = 6'(1 << idx);
      res.loop_pos  = 12'(held_pos);
      res.clk_level = clock_hi;
      expected_outputs.push_back(res);
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t want;
      string         names  [8];
      int            want_v [8];
      int            got_v  [8];
      if (expected_outputs.size() == 0) begin
        $display("%0t: result transfer with no pending item (left %0d, right %0d)",
                 $time, got.left_smp, got.right_smp);
        errors++;
        return;
      end
      want   = expected_outputs.pop_front();
      names  = '{"left_out", "right_out", "starved", "is_playing", "loop_toggle",
                 "loop_length", "loop_position", "clock_level"};
      want_v = '{want.left_smp, want.right_smp, want.starved, want.playing,
                 want.loop_toggle, want.len_steps, want.loop_pos, want.clk_level};
      got_v  = '{got.left_smp, got.right_smp, got.starved, got.playing,
                 got.loop_toggle, got.len_steps, got.loop_pos, got.clk_level};
      foreach (names[i]) begin
        if (want_v[i] != got_v[i]) begin
          $display("%0t: %s mismatch, expected %0d, actual %0d",
                   $time, names[i], want_v[i], got_v[i]);
          errors++;
        end
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [2:0]         op_i;
  logic signed [15:0] push_left_i;
  logic signed [15:0] push_right_i;
  logic [1:0]         trigger_levels_i;
  logic [11:0]        cv_length_i;
  logic [11:0]        cv_position_i;
  logic [11:0]        cv_clock_i;
  logic               producer_hold_i;
  logic               seek_pending_i;
  logic               play_value_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [15:0] left_out_o;
  logic signed [15:0] right_out_o;
  logic               starved_o;
  logic               is_playing_o;
  logic               loop_toggle_o;
  logic [5:0]         loop_length_o;
  logic [11:0]        loop_position_o;
  logic               clock_level_o;

  player_checker sb;
  int unsigned   cycle_count;
  int unsigned   idle_pct;
  int unsigned   stall_pct;
  int            len_walk;
  int            pos_walk;
  bit            clk_phase;
  item_t         taken_item;
  frame_result_t seen_result;

  stereo_ring_player_with_cv_conditioning u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .push_left_i      (push_left_i),
    .push_right_i     (push_right_i),
    .trigger_levels_i (trigger_levels_i),
    .cv_length_i      (cv_length_i),
    .cv_position_i    (cv_position_i),
    .cv_clock_i       (cv_clock_i),
    .producer_hold_i  (producer_hold_i),
    .seek_pending_i   (seek_pending_i),
    .play_value_i     (play_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .left_out_o       (left_out_o),
    .right_out_o      (right_out_o),
    .starved_o        (starved_o),
    .is_playing_o     (is_playing_o),
    .loop_toggle_o    (loop_toggle_o),
    .loop_length_o    (loop_length_o),
    .loop_position_o  (loop_position_o),
    .clock_level_o    (clock_level_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      taken_item.op             = op_i;
      taken_item.push_left      = push_left_i;
      taken_item.push_right     = push_right_i;
      taken_item.trigger_levels = trigger_levels_i;
      taken_item.cv_length      = cv_length_i;
      taken_item.cv_position    = cv_position_i;
      taken_item.cv_clock       = cv_clock_i;
      taken_item.hold           = producer_hold_i;
      taken_item.seek           = seek_pending_i;
      taken_item.play_value     = play_value_i;
      sb.note_item(taken_item);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_result.left_smp    = left_out_o;
      seen_result.right_smp   = right_out_o;
      seen_result.starved     = starved_o;
      seen_result.playing     = is_playing_o;
      seen_result.loop_toggle = loop_toggle_o;
      seen_result.len_steps   = loop_length_o;
      seen_result.loop_pos    = loop_position_o;
      seen_result.clk_level   = clock_level_o;
      sb.check_result(seen_result);
    end
  end

  function automatic item_t build_item(input logic [2:0] op,
                                       input logic signed [15:0] l,
                                       input logic signed [15:0] r,
                                       input logic [1:0] trig,
                                       input logic [11:0] len,
                                       input logic [11:0] pos,
                                       input logic [11:0] clk,
                                       input logic hold,
                                       input logic seek,
                                       input logic play);
    item_t it;
    it.op             = op;
    it.push_left      = l;
    it.push_right     = r;
    it.trigger_levels = trig;
    it.cv_length      = len;
    it.cv_position    = pos;
    it.cv_clock       = clk;
    it.hold           = hold;
    it.seek           = seek;
    it.play_value     = play;
    return it;
  endfunction

  function automatic logic signed [15:0] random_sample();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 5) return 16'sh8000;
    if (sel < 10) return 16'sh7FFF;
    return 16'($urandom);
  endfunction

  function automatic int next_cv(input int cur);
    int v;
    if ($urandom_range(99) < 10) return $urandom_range(4095);
    v = cur + $urandom_range(180) - 90;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v;
  endfunction

  function automatic item_t random_item();
    item_t       it;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 34) it.op = OP_PUSH;
    else if (sel < 70) it.op = OP_TICK;
    else if (sel < 82) it.op = OP_CTRL;
    else if (sel < 85) it.op = OP_FLUSH;
    else if (sel < 97) it.op = OP_PLAY;
    else it.op = 3'($urandom_range(7, 5));
    len_walk = next_cv(len_walk);
    pos_walk = next_cv(pos_walk);
    if ($urandom_range(99) < 25) clk_phase = !clk_phase;
    it.push_left      = random_sample();
    it.push_right     = random_sample();
    it.trigger_levels = 2'($urandom_range(3));
    it.cv_length      = 12'(len_walk);
    it.cv_position    = 12'(pos_walk);
    if ($urandom_range(99) < 10) it.cv_clock = 12'($urandom_range(4095));
    else if (clk_phase) it.cv_clock = 12'($urandom_range(4095, 1200));
    else it.cv_clock = 12'($urandom_range(600));
    it.hold       = ($urandom_range(99) < 10);
    it.seek       = ($urandom_range(99) < 15);
    it.play_value = ($urandom_range(99) < 80);
    return it;
  endfunction

  task automatic send_item(input item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    op_i             <= it.op;
    push_left_i      <= it.push_left;
    push_right_i     <= it.push_right;
    trigger_levels_i <= it.trigger_levels;
    cv_length_i      <= it.cv_length;
    cv_position_i    <= it.cv_position;
    cv_clock_i       <= it.cv_clock;
    producer_hold_i  <= it.hold;
    seek_pending_i   <= it.seek;
    play_value_i     <= it.play_value;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] value);
    logic [31:0] noise;
    noise   = $urandom;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= (idx == REG_SHIFT) ? {noise[31:4], value[3:0]} : {noise[31:12], value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk_i);
  endtask

  task automatic run_random(input int count);
    repeat (count) send_item(random_item());
  endtask

  initial begin
    sb               = new();
    cycle_count      = 0;
    idle_pct         = 0;
    stall_pct        = 0;
    len_walk         = 2048;
    pos_walk         = 2048;
    clk_phase        = 1'b0;
    rst_ni           <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    in_valid_i       <= 1'b0;
    out_stall_i      <= 1'b0;
    op_i             <= OP_PUSH;
    push_left_i      <= '0;
    push_right_i     <= '0;
    trigger_levels_i <= '0;
    cv_length_i      <= '0;
    cv_position_i    <= '0;
    cv_clock_i       <= '0;
    producer_hold_i  <= 1'b0;
    seek_pending_i   <= 1'b0;
    play_value_i     <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(build_item(OP_TICK, 0, 0, 2'b11, 0, 0, 0, 0, 0, 0));
    send_item(build_item(OP_CTRL, 0, 0, 2'b11, 0, 0, 0, 0, 0, 0));
    send_item(build_item(OP_CTRL, 0, 0, 2'b00, 4095, 4095, 4095, 0, 0, 0));
    send_item(build_item(OP_TICK, 0, 0, 2'b00, 0, 0, 0, 0, 0, 0));
    send_item(build_item(OP_PUSH, 16'sh7FFF, 16'sh8000, 0, 0, 0, 0, 0, 0, 0));
    send_item(build_item(OP_PUSH, 16'sh8000, 16'sh7FFF, 0, 0, 0, 0, 0, 0, 0));
    send_item(build_item(OP_PUSH, 16'shFFFF, 16'sh0001, 0, 0, 0, 0, 0, 0, 0));
    send_item(build_item(OP_PUSH, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    repeat (4) send_item(build_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(build_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 1, 0));
    send_item(build_item(OP_TICK, 0, 0, 0, 0, 0, 0, 1, 0, 0));
    send_item(build_item(OP_PLAY, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(build_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(build_item(OP_PLAY, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    send_item(build_item(OP_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(build_item(3'd5, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(build_item(3'd7, 16'sh7FFF, 16'sh7FFF, 3, 4095, 4095, 4095, 1, 1, 1));
    send_item(build_item(OP_CTRL, 0, 0, 2'b11, 4035, 4036, 0, 0, 0, 0));
    send_item(build_item(OP_CTRL, 0, 0, 2'b01, 3000, 100, 2000, 0, 0, 0));
    send_item(build_item(OP_CTRL, 0, 0, 2'b10, 2047, 0, 0, 0, 0, 0));
    send_item(build_item(3'd6, 0, 0, 0, 0, 0, 0, 0, 0, 0));

    wait_idle();
    write_reg(REG_DEADBAND, 12'd0);
    write_reg(REG_RISE, 12'd0);
    write_reg(REG_FALL, 12'd0);
    write_reg(REG_SHIFT, 12'd0);
    run_random(200);

    send_item(build_item(OP_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(build_item(OP_PLAY, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    repeat (48) send_item(build_item(OP_PUSH, random_sample(), random_sample(),
                                     0, 0, 0, 0, 0, 0, 0));
    repeat (64) send_item(build_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0,
                                     $urandom_range(1), 0));
    send_item(build_item(OP_PLAY, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    repeat (40) send_item(build_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));

    wait_idle();
    write_reg(REG_DEADBAND, 12'd4095);
    write_reg(REG_RISE, 12'd4095);
    write_reg(REG_FALL, 12'd4095);
    write_reg(REG_SHIFT, 12'd15);
    idle_pct  = 61;
    stall_pct = 0;
    run_random(200);

    wait_idle();
    write_reg(REG_DEADBAND, 12'($urandom_range(200)));
    write_reg(REG_RISE, 12'($urandom_range(1500, 300)));
    write_reg(REG_FALL, 12'($urandom_range(600, 100)));
    write_reg(REG_SHIFT, 12'($urandom_range(12, 1)));
    idle_pct  = 0;
    stall_pct = 61;
    run_random(200);

    wait_idle();
    write_reg(REG_DEADBAND, 12'($urandom_range(4095)));
    write_reg(REG_RISE, 12'($urandom_range(4095)));
    write_reg(REG_FALL, 12'($urandom_range(4095)));
    write_reg(REG_SHIFT, 12'($urandom_range(15)));
    idle_pct  = 15;
    stall_pct = 15;
    run_random(200);

    wait_idle();
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ stereo_ring_player_with_cv_conditioning.f @@
hdl/srp_pkg.sv
hdl/srp_ring.sv
hdl/srp_play.sv
hdl/srp_cv.sv
hdl/stereo_ring_player_with_cv_conditioning.sv
hdl/srp_checker.sv
tb/tb_top.sv
